[rtl/afs_pkg.sv]
// Shared types and constants for the arming and failsafe supervisor.
// Request and result layouts, vehicle modes, reject codes, register map.
// No dependencies.
package afs_pkg;

    // Field widths
    localparam int TIME_BITS  = 48;
    localparam int ANGLE_BITS = 16;
    localparam int TMO_BITS   = 24;
    localparam int TILT_BITS  = 15;
    localparam int COUNT_BITS = 32;
    localparam int NAV_BITS   = 8;

    // Squared tilt arithmetic
    localparam int SQ_BITS   = 2 * ANGLE_BITS;
    localparam int TSQ_BITS  = 2 * TILT_BITS;
    localparam int CMP_BITS  = (SQ_BITS > TSQ_BITS) ? SQ_BITS : TSQ_BITS;

    // Register map
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;
    localparam logic [1:0] REG_IMU_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_ATT_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_TILT_LIMIT  = 2'd2;

    // Reset values of the registers
    localparam logic [TMO_BITS-1:0]  IMU_TIMEOUT_RESET = TMO_BITS'(500000);
    localparam logic [TMO_BITS-1:0]  ATT_TIMEOUT_RESET = TMO_BITS'(500000);
    localparam logic [TILT_BITS-1:0] TILT_LIMIT_RESET  = TILT_BITS'(715);
    localparam logic [TSQ_BITS-1:0]  TILT_SQ_RESET     = TSQ_BITS'(715 * 715);

    localparam logic [NAV_BITS-1:0]  NAV_EMERGENCY = NAV_BITS'(255);

    typedef enum logic [1:0] {
        MODE_UNINIT    = 2'd0,
        MODE_STANDBY   = 2'd1,
        MODE_ARMED     = 2'd2,
        MODE_EMERGENCY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_NO_IMU    = 3'd1,
        RSN_IMU_STALE = 3'd2,
        RSN_NO_ATT    = 3'd3,
        RSN_ATT_STALE = 3'd4,
        RSN_NOT_LEVEL = 3'd5
    } reason_t;

    // One supervisor tick
    typedef struct packed {
        logic [TIME_BITS-1:0]         now_us;
        logic                         imu_update;
        logic [TIME_BITS-1:0]         imu_stamp;
        logic                         att_update;
        logic [TIME_BITS-1:0]         att_stamp;
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic                         arm_request;
        logic                         disarm_request;
    } req_item_t;

    // One tick result
    typedef struct packed {
        logic [1:0]            vehicle_mode;
        logic [NAV_BITS-1:0]   nav_code;
        logic                  motors_armed;
        logic                  failsafe_flag;
        logic [2:0]            reject_reason;
        logic [COUNT_BITS-1:0] transition_count;
    } rsp_item_t;

    // Registered tick with the angles already squared
    typedef struct packed {
        logic [TIME_BITS-1:0] now_us;
        logic                 imu_update;
        logic [TIME_BITS-1:0] imu_stamp;
        logic                 att_update;
        logic [TIME_BITS-1:0] att_stamp;
        logic [SQ_BITS-1:0]   roll_sq;
        logic [SQ_BITS-1:0]   pitch_sq;
        logic                 arm_request;
        logic                 disarm_request;
    } stage_t;

    // Live configuration handed to the core
    typedef struct packed {
        logic [TMO_BITS-1:0] imu_timeout;
        logic [TMO_BITS-1:0] att_timeout;
        logic [TSQ_BITS-1:0] tilt_sq;
    } cfg_t;

endpackage

[rtl/afs_cfg.sv]
// Configuration register file on an APB-style port.
// Keeps the timeouts, the tilt limit and its square. Depends on afs_pkg.
module afs_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [afs_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [afs_pkg::DATA_BITS-1:0]  pwdata,
    output logic [afs_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output afs_pkg::cfg_t                  cfg
);
    import afs_pkg::*;

    logic [TMO_BITS-1:0]  imu_timeout_reg;
    logic [TMO_BITS-1:0]  att_timeout_reg;
    logic [TILT_BITS-1:0] tilt_limit_reg;
    logic [TSQ_BITS-1:0]  tilt_sq_reg;
    logic [TILT_BITS-1:0] wr_tilt;
    logic [TSQ_BITS-1:0]  wr_tilt_sq;
    logic [1:0]           reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Square the tilt limit once at write time
    assign wr_tilt    = pwdata[TILT_BITS-1:0];
    assign wr_tilt_sq = TSQ_BITS'(wr_tilt) * TSQ_BITS'(wr_tilt);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imu_timeout_reg <= IMU_TIMEOUT_RESET;
            att_timeout_reg <= ATT_TIMEOUT_RESET;
            tilt_limit_reg  <= TILT_LIMIT_RESET;
            tilt_sq_reg     <= TILT_SQ_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_IMU_TIMEOUT: imu_timeout_reg <= pwdata[TMO_BITS-1:0];
                REG_ATT_TIMEOUT: att_timeout_reg <= pwdata[TMO_BITS-1:0];
                REG_TILT_LIMIT:
                begin
                    tilt_limit_reg <= wr_tilt;
                    tilt_sq_reg    <= wr_tilt_sq;
                end
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_IMU_TIMEOUT: prdata = DATA_BITS'(imu_timeout_reg);
            REG_ATT_TIMEOUT: prdata = DATA_BITS'(att_timeout_reg);
            REG_TILT_LIMIT:  prdata = DATA_BITS'(tilt_limit_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.imu_timeout = imu_timeout_reg;
    assign cfg.att_timeout = att_timeout_reg;
    assign cfg.tilt_sq     = tilt_sq_reg;

endmodule

[rtl/afs_ingress.sv]
// Input register stage: captures a request and squares its roll and pitch.
// Depends on afs_pkg.
module afs_ingress (
    input  logic                clk,
    input  logic                rst_n,
    input  afs_pkg::req_item_t  req_item,
    input  logic                load,
    input  logic                drain,
    output logic                stg_valid,
    output afs_pkg::stage_t     stg
);
    import afs_pkg::*;

    logic                  stg_valid_reg;
    logic                  stg_valid_next;
    stage_t                stg_reg;
    logic [ANGLE_BITS-1:0] roll_raw;
    logic [ANGLE_BITS-1:0] pitch_raw;
    logic [ANGLE_BITS-1:0] roll_mag;
    logic [ANGLE_BITS-1:0] pitch_mag;

    // Take magnitudes of the two's complement angles
    assign roll_raw  = req_item.roll_angle;
    assign pitch_raw = req_item.pitch_angle;
    assign roll_mag  = roll_raw[ANGLE_BITS-1]
                     ? (~roll_raw) + {{(ANGLE_BITS-1){1'b0}}, 1'b1} : roll_raw;
    assign pitch_mag = pitch_raw[ANGLE_BITS-1]
                     ? (~pitch_raw) + {{(ANGLE_BITS-1){1'b0}}, 1'b1} : pitch_raw;

    // Hold the stage until the core consumes it
    always_comb
    begin
        priority if (load)
            stg_valid_next = 1'b1;
        else if (drain)
            stg_valid_next = 1'b0;
        else
            stg_valid_next = stg_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else
            stg_valid_reg <= stg_valid_next;
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stg_reg.now_us         <= req_item.now_us;
            stg_reg.imu_update     <= req_item.imu_update;
            stg_reg.imu_stamp      <= req_item.imu_stamp;
            stg_reg.att_update     <= req_item.att_update;
            stg_reg.att_stamp      <= req_item.att_stamp;
            stg_reg.roll_sq        <= SQ_BITS'(roll_mag) * SQ_BITS'(roll_mag);
            stg_reg.pitch_sq       <= SQ_BITS'(pitch_mag) * SQ_BITS'(pitch_mag);
            stg_reg.arm_request    <= req_item.arm_request;
            stg_reg.disarm_request <= req_item.disarm_request;
        end
    end

    assign stg_valid = stg_valid_reg;
    assign stg       = stg_reg;

endmodule

[rtl/afs_core.sv]
// Supervisor state machine: sample bookkeeping, preflight checks, failsafe.
// Steps once per consumed request. Depends on afs_pkg.
module afs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  afs_pkg::stage_t     stg,
    input  afs_pkg::cfg_t       cfg,
    output afs_pkg::rsp_item_t  result
);
    import afs_pkg::*;

    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic                  armed_reg;
    logic                  armed_next;
    logic                  arm_pending_reg;
    logic                  arm_pending_next;
    logic                  disarm_pending_reg;
    logic                  disarm_pending_next;
    logic [TIME_BITS-1:0]  last_imu_stamp_reg;
    logic [TIME_BITS-1:0]  last_att_stamp_reg;
    logic [SQ_BITS-1:0]    last_roll_sq_reg;
    logic [SQ_BITS-1:0]    last_pitch_sq_reg;
    logic [COUNT_BITS-1:0] change_counter_reg;
    logic [COUNT_BITS-1:0] change_counter_next;
    reason_t               reason;

    logic [TIME_BITS-1:0]  imu_stamp;
    logic [TIME_BITS-1:0]  att_stamp;
    logic [SQ_BITS-1:0]    roll_sq;
    logic [SQ_BITS-1:0]    pitch_sq;
    logic [SQ_BITS-1:0]    tilt_sum;
    logic [TIME_BITS-1:0]  imu_age;
    logic [TIME_BITS-1:0]  att_age;
    logic                  imu_none;
    logic                  att_none;
    logic                  imu_stale;
    logic                  att_stale;
    logic                  not_level;
    logic                  sample_lost;
    logic                  arm_p;
    logic                  disarm_p;
    reason_t               preflight;

    // Fold in this tick's samples and requests
    assign imu_stamp = stg.imu_update ? stg.imu_stamp : last_imu_stamp_reg;
    assign att_stamp = stg.att_update ? stg.att_stamp : last_att_stamp_reg;
    assign roll_sq   = stg.att_update ? stg.roll_sq   : last_roll_sq_reg;
    assign pitch_sq  = stg.att_update ? stg.pitch_sq  : last_pitch_sq_reg;
    assign arm_p     = arm_pending_reg | stg.arm_request;
    assign disarm_p  = disarm_pending_reg | stg.disarm_request;

    // Sample ages wrap with the time base
    assign imu_age   = stg.now_us - imu_stamp;
    assign att_age   = stg.now_us - att_stamp;
    assign imu_none  = (imu_stamp == '0);
    assign att_none  = (att_stamp == '0);
    assign imu_stale = imu_age > TIME_BITS'(cfg.imu_timeout);
    assign att_stale = att_age > TIME_BITS'(cfg.att_timeout);
    assign tilt_sum  = roll_sq + pitch_sq;
    assign not_level = CMP_BITS'(tilt_sum) > CMP_BITS'(cfg.tilt_sq);
    assign sample_lost = (!imu_none && imu_stale) || (!att_none && att_stale);

    // Preflight checks in priority order
    always_comb
    begin
        priority if (imu_none)
            preflight = RSN_NO_IMU;
        else if (imu_stale)
            preflight = RSN_IMU_STALE;
        else if (att_none)
            preflight = RSN_NO_ATT;
        else if (att_stale)
            preflight = RSN_ATT_STALE;
        else if (not_level)
            preflight = RSN_NOT_LEVEL;
        else
            preflight = RSN_NONE;
    end

    // Next state
    always_comb
    begin
        mode_next           = mode_reg;
        armed_next          = armed_reg;
        arm_pending_next    = arm_p;
        disarm_pending_next = disarm_p;
        reason              = RSN_NONE;
        unique case (mode_reg)
            MODE_UNINIT:
            begin
                if (!imu_none && !att_none)
                    mode_next = MODE_STANDBY;
            end
            MODE_STANDBY:
            begin
                if (arm_p)
                begin
                    arm_pending_next = 1'b0;
                    reason           = preflight;
                    if (preflight == RSN_NONE)
                    begin
                        armed_next = 1'b1;
                        mode_next  = MODE_ARMED;
                    end
                end
            end
            MODE_ARMED:
            begin
                // A lost sample overrides a disarm, which is still consumed
                if (disarm_p)
                begin
                    disarm_pending_next = 1'b0;
                    armed_next          = 1'b0;
                    mode_next           = MODE_STANDBY;
                end
                if (sample_lost)
                begin
                    armed_next = 1'b0;
                    mode_next  = MODE_EMERGENCY;
                end
            end
            MODE_EMERGENCY:
            begin
                if (!armed_reg && disarm_p)
                begin
                    disarm_pending_next = 1'b0;
                    mode_next           = MODE_STANDBY;
                end
            end
            default: ;
        endcase
        change_counter_next = (mode_next != mode_reg)
                            ? change_counter_reg + COUNT_BITS'(1) : change_counter_reg;
    end

    // Result fields
    always_comb
    begin
        result.vehicle_mode     = mode_next;
        result.nav_code         = (mode_next == MODE_EMERGENCY)
                                ? NAV_EMERGENCY : NAV_BITS'(mode_next);
        result.motors_armed     = armed_next;
        result.failsafe_flag    = (mode_next == MODE_EMERGENCY);
        result.reject_reason    = reason;
        result.transition_count = change_counter_next;
    end

    // Advance the state on each consumed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_UNINIT;
            armed_reg          <= 1'b0;
            arm_pending_reg    <= 1'b0;
            disarm_pending_reg <= 1'b0;
            last_imu_stamp_reg <= '0;
            last_att_stamp_reg <= '0;
            last_roll_sq_reg   <= '0;
            last_pitch_sq_reg  <= '0;
            change_counter_reg <= '0;
        end
        else if (step)
        begin
            mode_reg           <= mode_next;
            armed_reg          <= armed_next;
            arm_pending_reg    <= arm_pending_next;
            disarm_pending_reg <= disarm_pending_next;
            last_imu_stamp_reg <= imu_stamp;
            last_att_stamp_reg <= att_stamp;
            last_roll_sq_reg   <= roll_sq;
            last_pitch_sq_reg  <= pitch_sq;
            change_counter_reg <= change_counter_next;
        end
    end

endmodule

[rtl/arming_failsafe_supervisor_top.sv]
// Top level of the arming and failsafe supervisor.
// Instantiates afs_cfg, afs_ingress and afs_core; depends on afs_pkg.
//
// One request is one supervisor tick and gives exactly one result. A request
// is registered on acceptance (roll and pitch are squared on the way in), the
// state machine steps once the result register is free and the result lands in
// an output register, so a new request is taken every cycle while the result
// side keeps up. The state step between the input register and the result
// register sets that rate.
// Sample ages wrap modulo 2^48; the supervisor arms only from standby after
// the IMU and attitude checks and the level check pass, and a lost sample while
// armed forces emergency. Registers: 0x0 IMU timeout (us), 0x4 attitude
// timeout (us), 0x8 tilt limit (Q3.12); write them only while no tick is in
// flight. There is no clearing pass after reset.
module arming_failsafe_supervisor_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  afs_pkg::req_item_t             req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output afs_pkg::rsp_item_t             rsp_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [afs_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [afs_pkg::DATA_BITS-1:0]  pwdata,
    output logic [afs_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);
    import afs_pkg::*;

    cfg_t      cfg;
    stage_t    stg;
    rsp_item_t result;
    rsp_item_t rsp_data_reg;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    logic      stg_valid;
    logic      advance;
    logic      step;
    logic      accept;

    // Handshake: the stage moves when the result register frees up
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign step      = stg_valid && advance;
    assign req_stall = stg_valid && !advance;
    assign accept    = req_valid && !req_stall;

    afs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afs_ingress u_ingress (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_data),
        .load      (accept),
        .drain     (step),
        .stg_valid (stg_valid),
        .stg       (stg)
    );

    afs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .stg    (stg),
        .cfg    (cfg),
        .result (result)
    );

    // Hold the result until it is taken
    always_comb
    begin
        priority if (step)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            rsp_data_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // A full stage that is not consumed must not be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid && !step) |-> !accept)
        else $error("request accepted over an unconsumed stage");

    // Every state step leaves a result waiting
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> rsp_valid_reg)
        else $error("state step without a result");

    // Emergency never reports armed motors
    a_failsafe_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_data_reg.failsafe_flag && rsp_data_reg.motors_armed))
        else $error("motors armed while in emergency");

endmodule

[tb/arming_failsafe_supervisor_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for arming_failsafe_supervisor_top.
// Holds a scoreboard class that predicts each tick result; depends on afs_pkg
// and the RTL top level only.
module arming_failsafe_supervisor_top_tb;
    import afs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_TICKS = 200;
    localparam int PHASES      = 8;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Supervisor predictor plus the queue of results still owed by the block
    class afs_scoreboard;
        logic [TMO_BITS-1:0]          imu_tmo;
        logic [TMO_BITS-1:0]          att_tmo;
        logic [TILT_BITS-1:0]         tilt;
        mode_t                        mode;
        logic                         armed;
        logic                         arm_wanted;
        logic                         disarm_wanted;
        logic [TIME_BITS-1:0]         imu_seen;
        logic [TIME_BITS-1:0]         att_seen;
        logic signed [ANGLE_BITS-1:0] roll;
        logic signed [ANGLE_BITS-1:0] pitch;
        logic [COUNT_BITS-1:0]        changes;
        rsp_item_t                    expected_q[$];
        int unsigned                  failures;
        int unsigned                  ticks;
        int unsigned                  checked;
        int unsigned                  rejects;
        int unsigned                  arms;
        int unsigned                  failsafes;

        function new();
            imu_tmo       = IMU_TIMEOUT_RESET;
            att_tmo       = ATT_TIMEOUT_RESET;
            tilt          = TILT_LIMIT_RESET;
            mode          = MODE_UNINIT;
            armed         = 1'b0;
            arm_wanted    = 1'b0;
            disarm_wanted = 1'b0;
            imu_seen      = '0;
            att_seen      = '0;
            roll          = '0;
            pitch         = '0;
            changes       = '0;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [DATA_BITS-1:0] value);
            case (idx)
                REG_IMU_TIMEOUT: imu_tmo = value[TMO_BITS-1:0];
                REG_ATT_TIMEOUT: att_tmo = value[TMO_BITS-1:0];
                REG_TILT_LIMIT:  tilt    = value[TILT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_BITS-1:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_IMU_TIMEOUT: return DATA_BITS'(imu_tmo);
                REG_ATT_TIMEOUT: return DATA_BITS'(att_tmo);
                default:         return DATA_BITS'(tilt);
            endcase
        endfunction

        // Age wraps with the time base; stale only strictly past the timeout
        function bit stale(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] stamp,
                           logic [TMO_BITS-1:0] tmo);
            logic [TIME_BITS-1:0] age;
            age = now - stamp;
            return age > TIME_BITS'(tmo);
        endfunction

        // Preflight checks in priority order
        function reason_t arm_check(logic [TIME_BITS-1:0] now);
            logic [ANGLE_BITS:0] r_mag;
            logic [ANGLE_BITS:0] p_mag;
            logic [35:0]         tilt_sum;
            logic [35:0]         lim_sq;
            r_mag = roll[ANGLE_BITS-1]  ? (ANGLE_BITS+1)'(-{roll[ANGLE_BITS-1], roll})
                                        : {1'b0, roll};
            p_mag = pitch[ANGLE_BITS-1] ? (ANGLE_BITS+1)'(-{pitch[ANGLE_BITS-1], pitch})
                                        : {1'b0, pitch};
            tilt_sum = 36'(r_mag) * 36'(r_mag) + 36'(p_mag) * 36'(p_mag);
            lim_sq   = 36'(tilt) * 36'(tilt);
            if (imu_seen == '0) return RSN_NO_IMU;
            if (stale(now, imu_seen, imu_tmo)) return RSN_IMU_STALE;
            if (att_seen == '0) return RSN_NO_ATT;
            if (stale(now, att_seen, att_tmo)) return RSN_ATT_STALE;
            if (tilt_sum > lim_sq) return RSN_NOT_LEVEL;
            return RSN_NONE;
        endfunction

        // Step the state machine for one accepted request
        function void note_tick(req_item_t t);
            mode_t     next_mode;
            reason_t   reason;
            rsp_item_t exp;
            if (t.imu_update) imu_seen = t.imu_stamp;
            if (t.att_update)
            begin
                att_seen = t.att_stamp;
                roll     = t.roll_angle;
                pitch    = t.pitch_angle;
            end
            if (t.arm_request) arm_wanted = 1'b1;
            if (t.disarm_request) disarm_wanted = 1'b1;
            next_mode = mode;
            reason    = RSN_NONE;
            case (mode)
                MODE_UNINIT:
                begin
                    if (imu_seen != '0 && att_seen != '0) next_mode = MODE_STANDBY;
                end
                MODE_STANDBY:
                begin
                    if (arm_wanted)
                    begin
                        arm_wanted = 1'b0;
                        reason = arm_check(t.now_us);
                        if (reason == RSN_NONE)
                        begin
                            armed = 1'b1;
                            next_mode = MODE_ARMED;
                            arms++;
                        end
                        else
                        begin
                            rejects++;
                        end
                    end
                end
                MODE_ARMED:
                begin
                    if (disarm_wanted)
                    begin
                        disarm_wanted = 1'b0;
                        armed = 1'b0;
                        next_mode = MODE_STANDBY;
                    end
                    // a lost sample overrides the disarm
                    if ((imu_seen != '0 && stale(t.now_us, imu_seen, imu_tmo)) ||
                        (att_seen != '0 && stale(t.now_us, att_seen, att_tmo)))
                    begin
                        armed = 1'b0;
                        next_mode = MODE_EMERGENCY;
                        failsafes++;
                    end
                end
                default:
                begin
                    if (!armed && disarm_wanted)
                    begin
                        disarm_wanted = 1'b0;
                        next_mode = MODE_STANDBY;
                    end
                end
            endcase
            if (next_mode != mode)
            begin
                mode = next_mode;
                changes++;
            end
            exp.vehicle_mode     = mode;
            exp.nav_code         = (mode == MODE_EMERGENCY) ? NAV_EMERGENCY : NAV_BITS'(mode);
            exp.motors_armed     = armed;
            exp.failsafe_flag    = (mode == MODE_EMERGENCY);
            exp.reject_reason    = reason;
            exp.transition_count = changes;
            expected_q.push_back(exp);
            ticks++;
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(rsp_item_t got);
            rsp_item_t exp;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result: mode %0d count %0d",
                                 got.vehicle_mode, got.transition_count));
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.vehicle_mode !== exp.vehicle_mode || got.nav_code !== exp.nav_code ||
                got.motors_armed !== exp.motors_armed ||
                got.failsafe_flag !== exp.failsafe_flag ||
                got.reject_reason !== exp.reject_reason ||
                got.transition_count !== exp.transition_count)
            begin
                report($sformatf({"result %0d mismatch: expected mode %0d nav %0d armed %b ",
                                  "failsafe %b reason %0d count %0d, got mode %0d nav %0d ",
                                  "armed %b failsafe %b reason %0d count %0d"},
                                 checked, exp.vehicle_mode, exp.nav_code, exp.motors_armed,
                                 exp.failsafe_flag, exp.reject_reason, exp.transition_count,
                                 got.vehicle_mode, got.nav_code, got.motors_armed,
                                 got.failsafe_flag, got.reject_reason,
                                 got.transition_count));
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_item_t             req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_item_t             rsp_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_BITS-1:0]  paddr     = '0;
    logic [DATA_BITS-1:0]  pwdata    = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    afs_scoreboard         sb = new();
    int                    pace = 1;
    int                    stall_left = 0;
    int unsigned           cycles = 0;
    logic [TIME_BITS-1:0]  clock_now = '0;

    arming_failsafe_supervisor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Note accepted requests and check accepted results at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
            if (req_valid && !req_stall) sb.note_tick(req_data);
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (pace == 0) return 0;
        if (r < ((pace == 1) ? 70 : 40)) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the result side in random runs
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall = 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = gap_len();
        end
    end

    // Sample time: mostly recent, some at the timeout edge, some old or ahead of now
    function automatic logic [TIME_BITS-1:0] pick_stamp(logic [TIME_BITS-1:0] now,
                                                         logic [TMO_BITS-1:0] tmo);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 70) return now - TIME_BITS'($urandom_range(0, 2000));
        if (r < 80) return now - TIME_BITS'(tmo) + TIME_BITS'($urandom_range(0, 4)) - 48'd2;
        if (r < 93) return now - TIME_BITS'($urandom_range(0, 2000000));
        return now + TIME_BITS'($urandom_range(1, 5000));
    endfunction

    // Angle mostly scaled around the tilt limit
    function automatic logic signed [ANGLE_BITS-1:0] pick_angle();
        int unsigned          span;
        logic [ANGLE_BITS-1:0] mag;
        if ($urandom_range(0, 9) == 0) return ANGLE_BITS'($urandom);
        span = sb.tilt + sb.tilt / 4 + 2;
        if (span > 32767) span = 32767;
        mag = ANGLE_BITS'($urandom_range(0, span));
        return $urandom_range(0, 1) ? $signed(-mag) : $signed(mag);
    endfunction

    // Next random tick: mostly a plausible 50 Hz stream, some pure noise
    function automatic req_item_t next_tick();
        req_item_t    t;
        logic [191:0] junk;
        int unsigned  r;
        junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        t = junk[$bits(req_item_t)-1:0];
        if ($urandom_range(0, 99) < 8) return t;
        r = $urandom_range(0, 99);
        if (r < 85) clock_now += TIME_BITS'($urandom_range(19800, 20200));
        else if (r < 95) clock_now += TIME_BITS'($urandom_range(0, 1000));
        else clock_now += TIME_BITS'($urandom_range(400000, 1200000));
        t.now_us = clock_now;
        t.imu_update = ($urandom_range(0, 99) < 80);
        if (t.imu_update) t.imu_stamp = pick_stamp(clock_now, sb.imu_tmo);
        t.att_update = ($urandom_range(0, 99) < 70);
        if (t.att_update)
        begin
            t.att_stamp   = pick_stamp(clock_now, sb.att_tmo);
            t.roll_angle  = pick_angle();
            t.pitch_angle = pick_angle();
        end
        t.arm_request    = ($urandom_range(0, 99) < 15);
        t.disarm_request = ($urandom_range(0, 99) < 7);
        return t;
    endfunction

    function automatic req_item_t tick(logic [TIME_BITS-1:0] now, logic iu,
                                       logic [TIME_BITS-1:0] is, logic au,
                                       logic [TIME_BITS-1:0] as, int roll, int pitch,
                                       logic arm, logic disarm);
        req_item_t t;
        t.now_us         = now;
        t.imu_update     = iu;
        t.imu_stamp      = is;
        t.att_update     = au;
        t.att_stamp      = as;
        t.roll_angle     = ANGLE_BITS'(roll);
        t.pitch_angle    = ANGLE_BITS'(pitch);
        t.arm_request    = arm;
        t.disarm_request = disarm;
        return t;
    endfunction

    // Present one request and hold it until accepted; called at the falling edge
    task automatic send_tick(input req_item_t t);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_data  = t;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off requests until every predicted result has come back
    task automatic drain();
        req_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register access: setup cycle then access cycle
    task automatic apb_access(input logic [1:0] idx, input logic is_write,
                              input logic [DATA_BITS-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = ADDR_BITS'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (is_write)
        begin
            sb.set_reg(idx, value);
        end
        else if (prdata !== sb.reg_value(idx))
        begin
            sb.report($sformatf("register %0d readback: expected %0h, got %0h",
                                idx, sb.reg_value(idx), prdata));
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
        apb_access(idx, 1'b1, value);
        apb_access(idx, 1'b0, '0);
    endtask

    // Register settings for each random phase
    task automatic set_phase_config(input int phase);
        case (phase)
            0:
            begin
                // keep reset values; a write past the map must change nothing
                apb_access(REG_UNUSED, 1'b1, 32'hFFFF_FFFF);
            end
            1:
            begin
                write_reg(REG_IMU_TIMEOUT, 32'd0);
                write_reg(REG_ATT_TIMEOUT, 32'd0);
                write_reg(REG_TILT_LIMIT, 32'd0);
            end
            2:
            begin
                write_reg(REG_IMU_TIMEOUT, 32'hFFFF_FFFF);
                write_reg(REG_ATT_TIMEOUT, 32'hFFFF_FFFF);
                write_reg(REG_TILT_LIMIT, 32'hFFFF_FFFF);
            end
            3:
            begin
                write_reg(REG_IMU_TIMEOUT, 32'd25000);
                write_reg(REG_ATT_TIMEOUT, 32'd21000);
                write_reg(REG_TILT_LIMIT, 32'd400);
                // run this phase across the time wrap
                clock_now = 48'hFFFF_FFFF_FFFF - 48'd2000000;
            end
            default:
            begin
                write_reg(REG_IMU_TIMEOUT,
                          {8'($urandom), 24'($urandom_range(1000, 700000))});
                write_reg(REG_ATT_TIMEOUT,
                          {8'($urandom), 24'($urandom_range(1000, 700000))});
                write_reg(REG_TILT_LIMIT,
                          {17'($urandom), ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                                      : 15'($urandom_range(0, 2000))});
            end
        endcase
    endtask

    initial
    begin
        int directed;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values of the registers
        apb_access(REG_IMU_TIMEOUT, 1'b0, '0);
        apb_access(REG_ATT_TIMEOUT, 1'b0, '0);
        apb_access(REG_TILT_LIMIT, 1'b0, '0);

        // Directed walk through the state machine and preflight outcomes
        pace = 1;
        send_tick(tick(48'd1000, 0, 0, 0, 0, 0, 0, 1, 0));                 // arm while uninit
        send_tick(tick(48'd2000, 1, 0, 0, 0, 0, 0, 0, 0));                 // zero stamp
        send_tick(tick(48'd3000, 1, 48'd2900, 1, 48'd2950, -32768, 32767, 0, 0));
        send_tick(tick(48'd4000, 0, 0, 0, 0, 0, 0, 0, 0));                 // not level
        send_tick(tick(48'd504001, 0, 0, 1, 48'd504000, 0, 0, 1, 0));      // IMU stale
        send_tick(tick(48'd1100000, 1, 48'd1100000, 0, 0, 0, 0, 1, 0));   // attitude stale
        send_tick(tick(48'd1120000, 1, 0, 0, 0, 0, 0, 1, 0));              // no IMU
        send_tick(tick(48'd1140000, 1, 48'd1139000, 1, 0, 715, 0, 1, 0));  // no attitude
        send_tick(tick(48'd1150000, 0, 0, 1, 48'd1149000, 716, 0, 1, 0));  // just past limit
        send_tick(tick(48'd1160000, 0, 0, 1, 48'd1159000, 715, 0, 1, 0));  // at limit: arm
        send_tick(tick(48'd1639000, 0, 0, 0, 0, 0, 0, 1, 0));              // age equals timeout
        send_tick(tick(48'd1639001, 0, 0, 0, 0, 0, 0, 0, 1));              // timeout beats disarm
        send_tick(tick(48'd1650000, 0, 0, 0, 0, 0, 0, 1, 0));              // arm in emergency
        send_tick(tick(48'd1660000, 0, 0, 0, 0, 0, 0, 0, 1));              // clear emergency
        send_tick(tick(48'd1680000, 1, 48'd1680000, 1, 48'd1680000, -715, 0, 0, 0));
        send_tick(tick(48'd1700000, 0, 0, 0, 0, 0, 0, 0, 1));              // plain disarm
        send_tick(tick(48'hFFFF_FFFF_FF00, 1, 48'hFFFF_FFFF_FE00, 1, 48'hFFFF_FFFF_FE00,
                       0, -715, 1, 0));
        send_tick(tick(48'h40, 0, 0, 0, 0, 0, 0, 0, 0));                   // across the wrap
        send_tick(tick(48'h80, 1, 48'h1000, 0, 0, 0, 0, 0, 0));            // stamp ahead of now
        send_tick(tick(48'h100, 0, 0, 0, 0, 0, 0, 1, 1));
        send_tick(tick(48'h200, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tick('1);
        send_tick('0);
        directed = 23;
        drain();

        // Random phases, each under its own register setting
        clock_now = 48'd5000000;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_phase_config(phase);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (n % 50 == 0) pace = $urandom_range(0, 2);
                if ($urandom_range(0, 299) == 0) drain();
                send_tick(next_tick());
            end
            drain();
        end

        $display("Ran %0d ticks (%0d directed) over %0d register settings; %0d results checked.",
                 sb.ticks, directed, PHASES, sb.checked);
        $display("Arms granted %0d, arm attempts rejected %0d, failsafe entries %0d.",
                 sb.arms, sb.rejects, sb.failsafes);
        if (sb.failures == 0 && sb.expected_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d failures", sb.failures);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
